>>> rtl/ffro_pkg.sv
// shared types and constants for the feedback frame receiver and odometry core
`default_nettype none

package ffro_pkg;

  localparam int FRAME_BYTES_DEF    = 22;
  localparam int POSITION_WIDTH_DEF = 48;
  localparam int RESTART_LIMIT      = 5;
  localparam int MAX_WORDS          = 16;
  localparam int CFG_W              = 16;
  localparam int CFG_IDX_W          = 2;
  localparam int ODO_W              = 48;
  localparam int PROC_STAGES        = 5;

  localparam logic [15:0] START_WORD_RST = 16'hABCD;
  localparam logic [15:0] WRAP_LOW_RST   = 16'd2700;
  localparam logic [15:0] WRAP_HIGH_RST  = 16'd6300;
  localparam logic [15:0] ENC_SPAN_RST   = 16'd9000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_WORD = 2'd0,
    CFG_WRAP_LOW   = 2'd1,
    CFG_WRAP_HIGH  = 2'd2,
    CFG_ENC_SPAN   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] wrap_low;
    logic signed [15:0] wrap_high;
    logic        [15:0] span;
  } cfg_t;

  typedef struct packed {
    logic               good;
    logic               gap;
    logic        [15:0] cmd_one;
    logic        [15:0] cmd_two;
    logic signed [15:0] spd_right;
    logic signed [15:0] spd_left;
    logic signed [15:0] cnt_right;
    logic signed [15:0] cnt_left;
    logic signed [15:0] battery;
    logic signed [15:0] temperature;
    logic        [15:0] led;
  } frame_t;

endpackage

`default_nettype wire

>>> rtl/ffro_frame_proc.sv
// frame pipeline: encoder unwrap, odometry accumulation and result register
`default_nettype none

module ffro_frame_proc #(
  parameter int POSITION_WIDTH = ffro_pkg::POSITION_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start_i,
  input  wire ffro_pkg::frame_t     frame_i,
  input  wire ffro_pkg::cfg_t       cfg_i,
  input  wire logic                 out_stall,
  output logic                      busy_o,
  output logic                      out_valid,
  output logic                      out_status,
  output logic signed [15:0]        out_speed_right,
  output logic signed [15:0]        out_speed_left,
  output logic signed [15:0]        out_battery_raw,
  output logic signed [15:0]        out_temperature_raw,
  output logic signed [ffro_pkg::ODO_W-1:0] out_odometry_right,
  output logic signed [ffro_pkg::ODO_W-1:0] out_odometry_left,
  output logic        [15:0]        out_command_one,
  output logic        [15:0]        out_command_two,
  output logic        [15:0]        out_led_word
);
  import ffro_pkg::*;

  localparam int PW = POSITION_WIDTH;
  localparam logic signed [PW-1:0] NEAR_LIM = PW'(RESTART_LIMIT);

  frame_t                   frm_r;
  logic [PROC_STAGES-1:0]   v_r;
  logic [31:0]              wraps_right_r, wraps_left_r;
  logic signed [15:0]       last_cnt_right_r, last_cnt_left_r;
  logic signed [48:0]       prod_right_r, prod_left_r;
  logic signed [48:0]       prod_right_nxt, prod_left_nxt;
  logic signed [PW-1:0]     pos_right_r, pos_left_r;
  logic signed [PW-1:0]     last_pos_right_r, last_pos_left_r;
  logic signed [PW-1:0]     delta_right_r, delta_left_r;
  logic signed [PW-1:0]     delta_right_nxt, delta_left_nxt;
  logic signed [PW-1:0]     total_right_r, total_left_r;
  logic signed [PW-1:0]     total_right_nxt, total_left_nxt;
  logic                     first_r;
  logic                     out_valid_r;
  logic                     restart;

  function automatic logic [31:0] wrap_next(
    input logic signed [15:0] c,
    input logic signed [15:0] l,
    input logic signed [15:0] lo,
    input logic signed [15:0] hi,
    input logic [31:0]        w
  );
    logic [31:0] r;
    priority if (c < lo && l > hi) begin
      r = w + 32'd1;
    end else if (c > hi && l < lo) begin
      r = w - 32'd1;
    end else begin
      r = w;
    end
    return r;
  endfunction

  assign prod_right_nxt = $signed(wraps_right_r) * $signed({1'b0, cfg_i.span});
  assign prod_left_nxt  = $signed(wraps_left_r) * $signed({1'b0, cfg_i.span});

  assign restart = frm_r.gap
                && (pos_right_r > -NEAR_LIM) && (pos_right_r < NEAR_LIM)
                && (pos_left_r > -NEAR_LIM) && (pos_left_r < NEAR_LIM);

  assign delta_right_nxt = (first_r || restart) ? '0 : pos_right_r - last_pos_right_r;
  assign delta_left_nxt  = (first_r || restart) ? '0 : pos_left_r - last_pos_left_r;

  assign total_right_nxt = total_right_r + delta_right_r;
  assign total_left_nxt  = total_left_r + delta_left_r;

  assign busy_o    = (|v_r) || out_valid_r;
  assign out_valid = out_valid_r;

  // one-frame-deep pipeline, only one frame in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r              <= '0;
      wraps_right_r    <= '0;
      wraps_left_r     <= '0;
      last_cnt_right_r <= '0;
      last_cnt_left_r  <= '0;
      last_pos_right_r <= '0;
      last_pos_left_r  <= '0;
      total_right_r    <= '0;
      total_left_r     <= '0;
      first_r          <= 1'b1;
      out_valid_r      <= 1'b0;
    end else begin
      v_r <= {v_r[PROC_STAGES-2:0], start_i};
      if (v_r[0] && frm_r.good) begin
        wraps_right_r    <= wrap_next(frm_r.cnt_right, last_cnt_right_r,
                                      cfg_i.wrap_low, cfg_i.wrap_high, wraps_right_r);
        wraps_left_r     <= wrap_next(frm_r.cnt_left, last_cnt_left_r,
                                      cfg_i.wrap_low, cfg_i.wrap_high, wraps_left_r);
        last_cnt_right_r <= frm_r.cnt_right;
        last_cnt_left_r  <= frm_r.cnt_left;
      end
      if (v_r[3] && frm_r.good) begin
        last_pos_right_r <= pos_right_r;
        last_pos_left_r  <= pos_left_r;
        first_r          <= 1'b0;
      end
      if (v_r[4]) begin
        total_right_r <= total_right_nxt;
        total_left_r  <= total_left_nxt;
      end
      if (v_r[4]) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      frm_r <= frame_i;
    end
    if (v_r[1]) begin
      prod_right_r <= prod_right_nxt;
      prod_left_r  <= prod_left_nxt;
    end
    if (v_r[2]) begin
      pos_right_r <= PW'(prod_right_r) + PW'(frm_r.cnt_right);
      pos_left_r  <= PW'(prod_left_r) + PW'(frm_r.cnt_left);
    end
    if (v_r[3]) begin
      delta_right_r <= frm_r.good ? delta_right_nxt : '0;
      delta_left_r  <= frm_r.good ? delta_left_nxt : '0;
    end
    if (v_r[4]) begin
      out_status          <= !frm_r.good;
      out_speed_right     <= frm_r.spd_right;
      out_speed_left      <= frm_r.spd_left;
      out_battery_raw     <= frm_r.battery;
      out_temperature_raw <= frm_r.temperature;
      out_odometry_right  <= ODO_W'(total_right_nxt);
      out_odometry_left   <= ODO_W'(total_left_nxt);
      out_command_one     <= frm_r.cmd_one;
      out_command_two     <= frm_r.cmd_two;
      out_led_word        <= frm_r.led;
    end
  end

endmodule

`default_nettype wire

>>> rtl/feedback_frame_rx_odometry_core.sv
// top level: byte receiver with start word resync, checksum and odometry results
//
//   channel | ports                            | direction
//   --------+----------------------------------+----------
//   input   | in_valid, in_stall, in_*         | byte items in
//   result  | out_valid, out_stall, out_*      | one item per completed frame
//   config  | cfg_wr_en, cfg_index, cfg_data   | register writes
//
// one byte is accepted every cycle while in_stall is low; out_valid rises once
// a frame's last accepted byte has passed the unwrap/multiply/add pipeline
// the byte that would complete a frame is stalled while the previous frame
// is still in the pipeline or its result is still waiting in the output register
// synchronous active-low reset clears counters, odometry state and valid flags
`default_nettype none

module feedback_frame_rx_odometry_core #(
  parameter int FRAME_BYTES    = ffro_pkg::FRAME_BYTES_DEF,
  parameter int POSITION_WIDTH = ffro_pkg::POSITION_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     in_rx_byte,
  input  wire logic                           in_quiet_gap,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_status,
  output logic signed [15:0]                  out_speed_right,
  output logic signed [15:0]                  out_speed_left,
  output logic signed [15:0]                  out_battery_raw,
  output logic signed [15:0]                  out_temperature_raw,
  output logic signed [ffro_pkg::ODO_W-1:0]   out_odometry_right,
  output logic signed [ffro_pkg::ODO_W-1:0]   out_odometry_left,
  output logic        [15:0]                  out_command_one,
  output logic        [15:0]                  out_command_two,
  output logic        [15:0]                  out_led_word,
  input  wire logic                           cfg_wr_en,
  input  wire logic [ffro_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ffro_pkg::CFG_W-1:0]     cfg_data
);
  import ffro_pkg::*;

  localparam int CNT_W = $clog2(FRAME_BYTES + 1);
  localparam int IDX_W = $clog2(FRAME_BYTES);
  localparam int NW    = FRAME_BYTES / 2;

  logic [15:0]      start_word_r;
  cfg_t             cfg_r;
  logic [7:0]       prev_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       store_r [FRAME_BYTES];

  logic             acc, sw_hit, in_frame, last_byte, complete, busy;
  logic [7:0]       frame_b [2*MAX_WORDS];
  logic [15:0]      word_w  [MAX_WORDS];
  logic [15:0]      data_w  [MAX_WORDS];
  logic [15:0]      xsum;
  frame_t           frame_d;

  assign acc       = in_valid && !in_stall;
  assign sw_hit    = {in_rx_byte, prev_r} == start_word_r;
  assign in_frame  = (cnt_r >= CNT_W'(2)) && (cnt_r < CNT_W'(FRAME_BYTES));
  assign last_byte = cnt_r == CNT_W'(FRAME_BYTES - 1);
  assign complete  = acc && !sw_hit && last_byte;
  assign in_stall  = busy && last_byte;

  always_comb begin
    priority if (!acc) begin
      cnt_nxt = cnt_r;
    end else if (sw_hit) begin
      cnt_nxt = CNT_W'(2);
    end else if (complete) begin
      cnt_nxt = '0;
    end else if (in_frame) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  // frame view with the completing byte in place
  always_comb begin
    for (int i = 0; i < 2*MAX_WORDS; i++) begin
      frame_b[i] = '0;
    end
    for (int i = 0; i < FRAME_BYTES; i++) begin
      frame_b[i] = (i == FRAME_BYTES - 1) ? in_rx_byte : store_r[i];
    end
    xsum = '0;
    for (int k = 0; k < MAX_WORDS; k++) begin
      word_w[k] = {frame_b[2*k+1], frame_b[2*k]};
      data_w[k] = (k < NW - 1) ? word_w[k] : '0;
      xsum      = xsum ^ data_w[k];
    end
    frame_d.good        = (word_w[0] == start_word_r) && (word_w[NW-1] == xsum);
    frame_d.gap         = in_quiet_gap;
    frame_d.cmd_one     = data_w[1];
    frame_d.cmd_two     = data_w[2];
    frame_d.spd_right   = data_w[3];
    frame_d.spd_left    = data_w[4];
    frame_d.cnt_right   = data_w[5];
    frame_d.cnt_left    = data_w[6];
    frame_d.battery     = data_w[7];
    frame_d.temperature = data_w[8];
    frame_d.led         = data_w[9];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_word_r    <= START_WORD_RST;
      cfg_r.wrap_low  <= WRAP_LOW_RST;
      cfg_r.wrap_high <= WRAP_HIGH_RST;
      cfg_r.span      <= ENC_SPAN_RST;
      prev_r          <= '0;
      cnt_r           <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_START_WORD: start_word_r    <= cfg_data;
          CFG_WRAP_LOW:   cfg_r.wrap_low  <= cfg_data;
          CFG_WRAP_HIGH:  cfg_r.wrap_high <= cfg_data;
          CFG_ENC_SPAN:   cfg_r.span      <= cfg_data;
        endcase
      end
      cnt_r <= cnt_nxt;
      if (acc) begin
        prev_r <= in_rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      if (sw_hit) begin
        store_r[0] <= prev_r;
        store_r[1] <= in_rx_byte;
      end else if (in_frame) begin
        store_r[cnt_r[IDX_W-1:0]] <= in_rx_byte;
      end
    end
  end

  ffro_frame_proc #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_proc (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start_i             (complete),
    .frame_i             (frame_d),
    .cfg_i               (cfg_r),
    .out_stall           (out_stall),
    .busy_o              (busy),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_speed_right     (out_speed_right),
    .out_speed_left      (out_speed_left),
    .out_battery_raw     (out_battery_raw),
    .out_temperature_raw (out_temperature_raw),
    .out_odometry_right  (out_odometry_right),
    .out_odometry_left   (out_odometry_left),
    .out_command_one     (out_command_one),
    .out_command_two     (out_command_two),
    .out_led_word        (out_led_word)
  );

endmodule

`default_nettype wire

>>> rtl/ffro_checker.sv
// port-level checks for the feedback frame receiver core, with bind
`default_nettype none

module ffro_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall
);

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  // a new result follows the frame's last accepted byte by a fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 6))
    else $error("result item without a completing byte");

  // only one frame in flight: no result directly after one is taken
  a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid)
    else $error("result items back to back");

endmodule

bind feedback_frame_rx_odometry_core ffro_checker u_ffro_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall)
);

`default_nettype wire
